// ===== design/kpnb_pkg.sv =====
// Shared types and constants for the keyframe pose nlerp blend unit.
// Used by every module of the block but kpnb_ram; depends on nothing else.
package kpnb_pkg;

  // Default keyframe table depth.
  localparam int SAMPLES_DEF = 256;

  // Depth of the command queue between the front and back ends.
  localparam int QDEPTH = 4;

  // Progress value that stands for 1.0 in Q0.16.
  localparam logic [16:0] P_ONE = 17'd65536;

  // Widths in the quaternion normalizer.
  localparam int RR_W        = 26;  // blended component at scale 2^24
  localparam int SQ_W        = 52;  // squared length, padded to an even width
  localparam int SQRT_STAGES = SQ_W / 2;
  localparam int N_W         = 26;  // floor square root of the squared length
  localparam int NUM_W       = 40;  // rounded division numerator
  localparam int DIV_STAGES  = 16;  // quotient bits

  // Largest positive Q1.15 value, also w of the identity quaternion.
  localparam logic signed [15:0] Q_ONE = 16'sd32767;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  // Which result an evaluate command produces.
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_MIX
  } sel_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         sample_index;
    logic [16:0]        progress;
    logic signed [31:0] in_tx;
    logic signed [31:0] in_ty;
    logic signed [31:0] in_tz;
    logic signed [15:0] in_qw;
    logic signed [15:0] in_qx;
    logic signed [15:0] in_qy;
    logic signed [15:0] in_qz;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
    logic signed [15:0] out_qw;
    logic signed [15:0] out_qx;
    logic signed [15:0] out_qy;
    logic signed [15:0] out_qz;
  } out_item_t;

  // One keyframe as stored in the table.
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } key_t;

  // Classified command held in the queue.
  typedef struct packed {
    logic        is_load;
    sel_t        sel;
    logic [7:0]  idx;
    logic [16:0] p;
    key_t        key;
  } cmd_t;

  // Data that travels with an evaluation through the normalizer.
  typedef struct packed {
    logic                      mix;
    logic signed [31:0]        tx;
    logic signed [31:0]        ty;
    logic signed [31:0]        tz;
    logic signed [15:0]        qw;
    logic signed [15:0]        qx;
    logic signed [15:0]        qy;
    logic signed [15:0]        qz;
    logic [3:0][RR_W-1:0]      rr;
  } side_t;

endpackage

// ===== design/kpnb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the keyframe table copies.
module kpnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/kpnb_front.sv =====
// Front end: accepts input transfers, classifies them and queues commands.
// Depends on kpnb_pkg.
module kpnb_front
  import kpnb_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     pop,
  output logic     head_valid,
  output cmd_t     head
);

  localparam int QA_W = $clog2(QDEPTH);
  localparam int QC_W = $clog2(QDEPTH + 1);

  cmd_t            cmd;
  logic            load_drop;
  logic            idx_hi;
  logic [16:0]     p_sat;
  logic            push;
  cmd_t            q_mem_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  // Classify the item: clamp the index, saturate progress, pick the result kind.
  always_comb begin
    load_drop   = int'(in_data.sample_index) >= SAMPLES;
    idx_hi      = int'(in_data.sample_index) > SAMPLES - 2;
    p_sat       = (in_data.progress > P_ONE) ? P_ONE : in_data.progress;
    cmd.is_load = (in_data.kind == KIND_LOAD);
    cmd.idx     = (!cmd.is_load && idx_hi) ? 8'(SAMPLES - 2) : in_data.sample_index;
    cmd.p       = p_sat;
    priority if (p_sat == '0) begin
      cmd.sel = SEL_A;
    end else if (p_sat == P_ONE) begin
      cmd.sel = SEL_B;
    end else begin
      cmd.sel = SEL_MIX;
    end
    cmd.key.tx = in_data.in_tx;
    cmd.key.ty = in_data.in_ty;
    cmd.key.tz = in_data.in_tz;
    cmd.key.qw = in_data.in_qw;
    cmd.key.qx = in_data.in_qx;
    cmd.key.qy = in_data.in_qy;
    cmd.key.qz = in_data.in_qz;
  end

  // A load beyond the table is accepted and dropped.
  assign in_ready   = (count_r != QC_W'(QDEPTH));
  assign push       = in_valid && in_ready && !(cmd.is_load && load_drop);
  assign head_valid = (count_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

  // Queue pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? QA_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QA_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = QC_W'(count_r + QC_W'(push) - QC_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

`ifndef SYNTHESIS
  // The back end never takes a command from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("command queue underflow");
`endif

endmodule

// ===== design/kpnb_blend.sv =====
// Back end, first half: keyframe table, weighted products, translation blend
// and squared quaternion length. Depends on kpnb_pkg and kpnb_ram.
module kpnb_blend
  import kpnb_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            head_valid,
  input  cmd_t            head,
  output logic            pop,
  output logic            vld_o,
  output side_t           side_o,
  output logic [SQ_W-1:0] sq_o
);

  localparam int AW = $clog2(SAMPLES);
  localparam int KW = $bits(key_t);

  logic          we;
  logic [AW-1:0] addr_a, addr_b;
  logic [KW-1:0] ka_raw, kb_raw;
  key_t          ka, kb;

  // Commands leave the queue whenever the pipeline moves and the queue is not empty.
  assign pop    = adv && head_valid;
  assign we     = pop && head.is_load;
  assign addr_a = AW'(head.idx);
  assign addr_b = AW'({1'b0, head.idx} + 9'd1);

  // Two copies of the table so that both keyframes are read in the same cycle.
  kpnb_ram #(.WIDTH(KW), .DEPTH(SAMPLES)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (addr_a),
    .wdata (KW'(head.key)),
    .re    (adv),
    .raddr (addr_a),
    .rdata (ka_raw)
  );

  kpnb_ram #(.WIDTH(KW), .DEPTH(SAMPLES)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (addr_a),
    .wdata (KW'(head.key)),
    .re    (adv),
    .raddr (addr_b),
    .rdata (kb_raw)
  );

  assign ka = key_t'(ka_raw);
  assign kb = key_t'(kb_raw);

  // Stage 1: table read in flight.
  logic        vld1_r, mix1_r, selb1_r;
  logic [16:0] p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= pop && !head.is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mix1_r  <= (head.sel == SEL_MIX);
      selb1_r <= (head.sel == SEL_B);
      p1_r    <= head.p;
    end
  end

  // Stage 2: weighted products and dot product terms.
  logic signed [17:0] w0_s, w1_s;
  logic signed [31:0] ta [3];
  logic signed [31:0] tb [3];
  logic signed [15:0] qa [4];
  logic signed [15:0] qb [4];
  logic signed [49:0] pta_nxt [3];
  logic signed [49:0] ptb_nxt [3];
  logic signed [33:0] pqa_nxt [4];
  logic signed [33:0] pqb_nxt [4];
  logic signed [31:0] dot_nxt [4];
  key_t               ep_nxt;

  always_comb begin
    w0_s  = $signed({1'b0, P_ONE - p1_r});
    w1_s  = $signed({1'b0, p1_r});
    ta[0] = ka.tx;
    ta[1] = ka.ty;
    ta[2] = ka.tz;
    tb[0] = kb.tx;
    tb[1] = kb.ty;
    tb[2] = kb.tz;
    qa[0] = ka.qw;
    qa[1] = ka.qx;
    qa[2] = ka.qy;
    qa[3] = ka.qz;
    qb[0] = kb.qw;
    qb[1] = kb.qx;
    qb[2] = kb.qy;
    qb[3] = kb.qz;
    for (int k = 0; k < 3; k++) begin
      pta_nxt[k] = ta[k] * w0_s;
      ptb_nxt[k] = tb[k] * w1_s;
    end
    for (int k = 0; k < 4; k++) begin
      pqa_nxt[k] = qa[k] * w0_s;
      pqb_nxt[k] = qb[k] * w1_s;
      dot_nxt[k] = qa[k] * qb[k];
    end
    ep_nxt = selb1_r ? kb : ka;
  end

  logic               vld2_r, mix2_r;
  logic signed [49:0] pta2_r [3];
  logic signed [49:0] ptb2_r [3];
  logic signed [33:0] pqa2_r [4];
  logic signed [33:0] pqb2_r [4];
  logic signed [31:0] dot2_r [4];
  key_t               ep2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mix2_r <= mix1_r;
      ep2_r  <= ep_nxt;
      for (int k = 0; k < 3; k++) begin
        pta2_r[k] <= pta_nxt[k];
        ptb2_r[k] <= ptb_nxt[k];
      end
      for (int k = 0; k < 4; k++) begin
        pqa2_r[k] <= pqa_nxt[k];
        pqb2_r[k] <= pqb_nxt[k];
        dot2_r[k] <= dot_nxt[k];
      end
    end
  end

  // Stage 3: rounded translation blend and sign of the dot product.
  logic signed [50:0] tsum;
  logic signed [33:0] dsum;
  logic signed [31:0] tmix_nxt [3];
  logic               dneg_nxt;

  always_comb begin
    tsum = '0;
    for (int k = 0; k < 3; k++) begin
      tsum        = 51'(pta2_r[k]) + 51'(ptb2_r[k]) + 51'sd32768;
      tmix_nxt[k] = tsum[47:16];
    end
    dsum     = 34'(dot2_r[0]) + 34'(dot2_r[1]) + 34'(dot2_r[2]) + 34'(dot2_r[3]);
    dneg_nxt = dsum[33];
  end

  logic               vld3_r, mix3_r, dneg3_r;
  logic signed [31:0] tmix3_r [3];
  logic signed [33:0] pqa3_r [4];
  logic signed [33:0] pqb3_r [4];
  key_t               ep3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mix3_r  <= mix2_r;
      dneg3_r <= dneg_nxt;
      ep3_r   <= ep2_r;
      for (int k = 0; k < 3; k++) begin
        tmix3_r[k] <= tmix_nxt[k];
      end
      for (int k = 0; k < 4; k++) begin
        pqa3_r[k] <= pqa2_r[k];
        pqb3_r[k] <= pqb2_r[k];
      end
    end
  end

  // Stage 4: quaternion blend with the shorter-arc sign, scaled to 2^24.
  logic signed [34:0] rsum;
  side_t              side4_nxt;

  always_comb begin
    rsum          = '0;
    side4_nxt.mix = mix3_r;
    side4_nxt.tx  = mix3_r ? tmix3_r[0] : ep3_r.tx;
    side4_nxt.ty  = mix3_r ? tmix3_r[1] : ep3_r.ty;
    side4_nxt.tz  = mix3_r ? tmix3_r[2] : ep3_r.tz;
    side4_nxt.qw  = ep3_r.qw;
    side4_nxt.qx  = ep3_r.qx;
    side4_nxt.qy  = ep3_r.qy;
    side4_nxt.qz  = ep3_r.qz;
    for (int k = 0; k < 4; k++) begin
      rsum = dneg3_r ? 35'(pqa3_r[k]) - 35'(pqb3_r[k])
                     : 35'(pqa3_r[k]) + 35'(pqb3_r[k]);
      side4_nxt.rr[k] = rsum[32:7];
    end
  end

  logic  vld4_r;
  side_t side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4_r <= side4_nxt;
    end
  end

  // Stage 5: squares of the blended components.
  logic signed [51:0] sqp;
  logic [48:0]        sq5_nxt [4];

  always_comb begin
    sqp = '0;
    for (int k = 0; k < 4; k++) begin
      sqp        = $signed(side4_r.rr[k]) * $signed(side4_r.rr[k]);
      sq5_nxt[k] = sqp[48:0];
    end
  end

  logic        vld5_r;
  side_t       side5_r;
  logic [48:0] sq5_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (adv) begin
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side5_r <= side4_r;
      for (int k = 0; k < 4; k++) begin
        sq5_r[k] <= sq5_nxt[k];
      end
    end
  end

  // Stage 6: squared length of the blended quaternion.
  logic [50:0]     sqsum;
  logic            vld6_r;
  side_t           side6_r;
  logic [SQ_W-1:0] sq6_r;

  assign sqsum = 51'(sq5_r[0]) + 51'(sq5_r[1]) + 51'(sq5_r[2]) + 51'(sq5_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else if (adv) begin
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side6_r <= side5_r;
      sq6_r   <= SQ_W'(sqsum);
    end
  end

  assign vld_o  = vld6_r;
  assign side_o = side6_r;
  assign sq_o   = sq6_r;

endmodule

// ===== design/kpnb_norm.sv =====
// Back end, second half: pipelined square root, rounded division of each
// component by the length, saturation and the output register. Uses kpnb_pkg.
module kpnb_norm
  import kpnb_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            vld_i,
  input  side_t           side_i,
  input  logic [SQ_W-1:0] sq_i,
  output logic            out_valid,
  output out_item_t       out_data
);

  localparam int SL = SQRT_STAGES;
  localparam int DL = DIV_STAGES;

  // Square root: one result bit per stage.
  logic [SL-1:0]   sv_r, sv_in;
  side_t           ss_r [SL];
  side_t           ss_in [SL];
  logic [SQ_W-1:0] sx_r [SL];
  logic [SQ_W-1:0] sx_in [SL];
  logic [SQ_W-1:0] sx_nxt [SL];
  logic [SQ_W-1:0] sres_r [SL];
  logic [SQ_W-1:0] sres_in [SL];
  logic [SQ_W-1:0] sres_nxt [SL];

  always_comb begin
    logic [SQ_W-1:0] sbit;
    logic [SQ_W-1:0] trial;
    sv_in[0]   = vld_i;
    ss_in[0]   = side_i;
    sx_in[0]   = sq_i;
    sres_in[0] = '0;
    for (int s = 1; s < SL; s++) begin
      sv_in[s]   = sv_r[s-1];
      ss_in[s]   = ss_r[s-1];
      sx_in[s]   = sx_r[s-1];
      sres_in[s] = sres_r[s-1];
    end
    for (int s = 0; s < SL; s++) begin
      sbit  = SQ_W'(1) << (2 * (SL - 1 - s));
      trial = sres_in[s] + sbit;
      if (sx_in[s] >= trial) begin
        sx_nxt[s]   = sx_in[s] - trial;
        sres_nxt[s] = (sres_in[s] >> 1) + sbit;
      end else begin
        sx_nxt[s]   = sx_in[s];
        sres_nxt[s] = sres_in[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r <= sv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < SL; s++) begin
        ss_r[s]   <= ss_in[s];
        sx_r[s]   <= sx_nxt[s];
        sres_r[s] <= sres_nxt[s];
      end
    end
  end

  // Numerators: |rr| * 2^15 plus half the length for round to nearest.
  logic [N_W-1:0]         n_root;
  logic signed [RR_W-1:0] mag;
  logic [NUM_W-1:0]       num_nxt [4];

  assign n_root = sres_r[SL-1][N_W-1:0];

  always_comb begin
    mag = '0;
    for (int k = 0; k < 4; k++) begin
      mag        = ss_r[SL-1].rr[k][RR_W-1] ? -$signed(ss_r[SL-1].rr[k])
                                            : $signed(ss_r[SL-1].rr[k]);
      num_nxt[k] = NUM_W'({mag[RR_W-2:0], 15'b0}) + NUM_W'(n_root >> 1);
    end
  end

  logic             nv_r;
  side_t            ns_r;
  logic [N_W-1:0]   nn_r;
  logic [NUM_W-1:0] num_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (adv) begin
      nv_r <= sv_r[SL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ns_r <= ss_r[SL-1];
      nn_r <= n_root;
      for (int k = 0; k < 4; k++) begin
        num_r[k] <= num_nxt[k];
      end
    end
  end

  // Restoring division: one quotient bit per stage, four lanes side by side.
  logic [DL-1:0]    dv_r, dv_in;
  side_t            ds_r [DL];
  side_t            ds_in [DL];
  logic [N_W-1:0]   dn_r [DL];
  logic [N_W-1:0]   dn_in [DL];
  logic [NUM_W-1:0] drem_r [DL][4];
  logic [NUM_W-1:0] drem_in [DL][4];
  logic [NUM_W-1:0] drem_nxt [DL][4];
  logic [15:0]      dq_r [DL][4];
  logic [15:0]      dq_in [DL][4];
  logic [15:0]      dq_nxt [DL][4];

  always_comb begin
    logic [NUM_W+1:0] dsh;
    dv_in[0] = nv_r;
    ds_in[0] = ns_r;
    dn_in[0] = nn_r;
    for (int k = 0; k < 4; k++) begin
      drem_in[0][k] = num_r[k];
      dq_in[0][k]   = '0;
    end
    for (int d = 1; d < DL; d++) begin
      dv_in[d] = dv_r[d-1];
      ds_in[d] = ds_r[d-1];
      dn_in[d] = dn_r[d-1];
      for (int k = 0; k < 4; k++) begin
        drem_in[d][k] = drem_r[d-1][k];
        dq_in[d][k]   = dq_r[d-1][k];
      end
    end
    for (int d = 0; d < DL; d++) begin
      dsh = (NUM_W + 2)'(dn_in[d]) << (DL - 1 - d);
      for (int k = 0; k < 4; k++) begin
        if ((NUM_W + 2)'(drem_in[d][k]) >= dsh) begin
          drem_nxt[d][k] = NUM_W'((NUM_W + 2)'(drem_in[d][k]) - dsh);
          dq_nxt[d][k]   = dq_in[d][k] | (16'(1) << (DL - 1 - d));
        end else begin
          drem_nxt[d][k] = drem_in[d][k];
          dq_nxt[d][k]   = dq_in[d][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= dv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < DL; d++) begin
        ds_r[d] <= ds_in[d];
        dn_r[d] <= dn_in[d];
        for (int k = 0; k < 4; k++) begin
          drem_r[d][k] <= drem_nxt[d][k];
          dq_r[d][k]   <= dq_nxt[d][k];
        end
      end
    end
  end

  // Sign, saturation, zero-length and end-point selection.
  logic signed [15:0] qs [4];
  logic [15:0]        qv;
  out_item_t          out_nxt;
  side_t              fs;

  always_comb begin
    fs = ds_r[DL-1];
    qv = '0;
    for (int k = 0; k < 4; k++) begin
      qv = dq_r[DL-1][k];
      if (fs.rr[k][RR_W-1]) begin
        qs[k] = 16'(-{1'b0, qv});
      end else begin
        qs[k] = (qv > 16'd32767) ? Q_ONE : qv;
      end
    end
    out_nxt.out_tx = fs.tx;
    out_nxt.out_ty = fs.ty;
    out_nxt.out_tz = fs.tz;
    priority if (!fs.mix) begin
      out_nxt.out_qw = fs.qw;
      out_nxt.out_qx = fs.qx;
      out_nxt.out_qy = fs.qy;
      out_nxt.out_qz = fs.qz;
    end else if (dn_r[DL-1] == '0) begin
      out_nxt.out_qw = Q_ONE;
      out_nxt.out_qx = '0;
      out_nxt.out_qy = '0;
      out_nxt.out_qz = '0;
    end else begin
      out_nxt.out_qw = qs[0];
      out_nxt.out_qx = qs[1];
      out_nxt.out_qy = qs[2];
      out_nxt.out_qz = qs[3];
    end
  end

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The square root remainder stays within 2n, so n is the floor root.
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[SL-1] |-> sx_r[SL-1] <= (sres_r[SL-1] << 1))
    else $error("square root remainder out of range");

  // A zero root only follows a quaternion whose components are all zero.
  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    nv_r && nn_r == '0 |-> ns_r.rr == '0)
    else $error("zero root with nonzero components");

  // Each component is at most the length, so quotients never pass 1.0.
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DL-1] && dn_r[DL-1] != '0 |->
      dq_r[DL-1][0] <= 16'd32768 && dq_r[DL-1][1] <= 16'd32768 &&
      dq_r[DL-1][2] <= 16'd32768 && dq_r[DL-1][3] <= 16'd32768)
    else $error("normalized component above one");
`endif

endmodule

// ===== design/keyframe_pose_nlerp_blend_unit.sv =====
// Top level of the keyframe pose nlerp blend unit.
// Depends on kpnb_pkg, kpnb_front, kpnb_blend and kpnb_norm.
//
// Keyframe pose blender. A load transfer writes one keyframe (Q16.16
// translation, Q1.15 quaternion) into a table of SAMPLES entries; a load to
// an index past the table is accepted and ignored. An evaluate transfer
// blends keyframes i and i+1 at progress p (Q0.16, saturated to 1.0, index
// clamped to SAMPLES-2): translations linearly, quaternions by nlerp along
// the shorter arc, renormalized. One item is accepted per cycle while the
// command queue has room; results pass through the blend stages, the
// 26-stage square root and the 16-stage divider to the output register. A
// four-entry command queue sits in front of the pipeline, so input keeps
// flowing while the output stalls, until the queue is full. Loads and evaluations
// take effect in order; an evaluation reading a keyframe that was never
// loaded returns undefined data.
module keyframe_pose_nlerp_blend_unit
  import kpnb_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic            adv;
  logic            pop;
  logic            head_valid;
  cmd_t            head;
  logic            bl_vld;
  side_t           bl_side;
  logic [SQ_W-1:0] bl_sq;

  // The whole back end moves when the output register is free or being read.
  assign adv = !out_valid || out_ready;

  kpnb_front #(.SAMPLES(SAMPLES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  kpnb_blend #(.SAMPLES(SAMPLES)) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .vld_o      (bl_vld),
    .side_o     (bl_side),
    .sq_o       (bl_sq)
  );

  kpnb_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .vld_i     (bl_vld),
    .side_i    (bl_side),
    .sq_i      (bl_sq),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
